// ===== design/rmd_pkg.sv =====
package rmd_pkg;

  localparam int WORD_BITS   = 62;
  localparam int MAX_Q_LIMBS = 8;
  localparam int MAX_P_LIMBS = 4;
  localparam int Q_IDX_W     = 3;
  localparam int P_IDX_W     = 2;
  localparam int QCNT_W      = 4;
  localparam int PCNT_W      = 3;
  localparam int CNT_W       = $clog2(WORD_BITS);
  localparam int PHAT_DEPTH  = MAX_Q_LIMBS * MAX_P_LIMBS;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RES  = 1'b1;

  localparam logic REG_Q_LIMBS = 1'b0;
  localparam logic REG_P_LIMBS = 1'b1;

  typedef enum logic [2:0] {
    TBL_Q_MOD    = 3'd0,
    TBL_P_MOD    = 3'd1,
    TBL_PHAT_INV = 3'd2,
    TBL_PHAT_Q   = 3'd3,
    TBL_P_INV    = 3'd4
  } tbl_t;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    SEL_SCALE = 3'd0,
    SEL_TERM  = 3'd1,
    SEL_ACC   = 3'd2,
    SEL_DIFF  = 3'd3,
    SEL_OUT   = 3'd4
  } sel_t;

  typedef struct packed {
    logic               start;
    sel_t               sel;
    logic [Q_IDX_W-1:0] limb;
    logic [P_IDX_W-1:0] pidx;
    logic               accept;
    logic               load_out;
    logic               last;
  } ctl_cmd_t;

  typedef struct packed {
    logic done;
    logic busy;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== design/rmd_modarith.sv =====
module rmd_modarith
  import rmd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  op_t                  op,
  input  logic [WORD_BITS-1:0] a,
  input  logic [WORD_BITS-1:0] b,
  input  logic [WORD_BITS-1:0] m,
  output logic                 done,
  output logic                 busy,
  output logic [WORD_BITS-1:0] result
);

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_RED  = 4'b0010,
    U_MUL  = 4'b0100,
    U_FIN  = 4'b1000
  } uphase_t;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(WORD_BITS - 1);

  uphase_t              phase;
  op_t                  op_r;
  logic [CNT_W-1:0]     cnt;
  logic [WORD_BITS-1:0] x_sh, y_sh, ra, rb, m_r, r;
  logic [WORD_BITS:0]   ra_sh, rb_sh, dbl, s_mul, s_add, m_ext;
  logic [WORD_BITS-1:0] ra_nx, rb_nx, d_mul, r_mul, add_res, sub_res, fin_res;

  // One bit of each operand is folded into its remainder per cycle, then, for a
  // multiply, one bit of the multiplier per cycle by double-and-add.
  always_comb begin
    m_ext   = {1'b0, m_r};
    ra_sh   = {ra, x_sh[WORD_BITS-1]};
    rb_sh   = {rb, y_sh[WORD_BITS-1]};
    ra_nx   = (ra_sh >= m_ext) ? WORD_BITS'(ra_sh - m_ext) : ra_sh[WORD_BITS-1:0];
    rb_nx   = (rb_sh >= m_ext) ? WORD_BITS'(rb_sh - m_ext) : rb_sh[WORD_BITS-1:0];
    dbl     = {r, 1'b0};
    d_mul   = (dbl >= m_ext) ? WORD_BITS'(dbl - m_ext) : dbl[WORD_BITS-1:0];
    s_mul   = {1'b0, d_mul} + {1'b0, ra};
    r_mul   = y_sh[WORD_BITS-1] ?
              ((s_mul >= m_ext) ? WORD_BITS'(s_mul - m_ext) : s_mul[WORD_BITS-1:0]) : d_mul;
    s_add   = {1'b0, ra} + {1'b0, rb};
    add_res = (s_add >= m_ext) ? WORD_BITS'(s_add - m_ext) : s_add[WORD_BITS-1:0];
    sub_res = (ra >= rb) ? ra - rb : ra + m_r - rb;
    unique case (op_r)
      OP_MUL:  fin_res = r;
      OP_ADD:  fin_res = add_res;
      OP_SUB:  fin_res = sub_res;
      default: fin_res = '0;
    endcase
  end

  assign busy = (phase != U_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (phase == U_FIN);
      unique case (phase)
        U_IDLE: begin
          if (start) begin
            x_sh  <= a;
            y_sh  <= b;
            m_r   <= m;
            op_r  <= op;
            ra    <= '0;
            rb    <= '0;
            cnt   <= CNT_MAX;
            phase <= U_RED;
          end
        end
        U_RED: begin
          ra   <= ra_nx;
          rb   <= rb_nx;
          x_sh <= x_sh << 1;
          if (cnt == '0) begin
            y_sh  <= rb_nx;
            r     <= '0;
            cnt   <= CNT_MAX;
            phase <= (op_r == OP_MUL) ? U_MUL : U_FIN;
          end else begin
            y_sh <= y_sh << 1;
            cnt  <= cnt - 1'b1;
          end
        end
        U_MUL: begin
          r    <= r_mul;
          y_sh <= y_sh << 1;
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            phase <= U_FIN;
          end
        end
        U_FIN: begin
          result <= (m_r == '0) ? '0 : fin_res;
          phase  <= U_IDLE;
        end
        default: phase <= U_IDLE;
      endcase
    end
  end

endmodule

// ===== design/rmd_dp.sv =====
module rmd_dp
  import rmd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_cmd_t             cmd,
  output dp_stat_t             status,
  input  logic                 command,
  input  logic [2:0]           table_req,
  input  logic [P_IDX_W-1:0]   p_index,
  input  logic [Q_IDX_W-1:0]   q_index,
  input  logic                 in_p_basis,
  input  logic [WORD_BITS-1:0] value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [Q_IDX_W-1:0]   limb,
  output logic [WORD_BITS-1:0] residue,
  output logic                 last
);

  logic [WORD_BITS-1:0] q_mod   [MAX_Q_LIMBS];
  logic [WORD_BITS-1:0] p_mod   [MAX_P_LIMBS];
  logic [WORD_BITS-1:0] phat_inv[MAX_P_LIMBS];
  logic [WORD_BITS-1:0] phat_q  [PHAT_DEPTH];
  logic [WORD_BITS-1:0] p_inv   [MAX_Q_LIMBS];
  logic [WORD_BITS-1:0] q_res   [MAX_Q_LIMBS];
  logic [WORD_BITS-1:0] acc     [MAX_Q_LIMBS];
  logic [WORD_BITS-1:0] v_reg, t_reg;
  logic [WORD_BITS-1:0] op_a, op_b, op_m, u_res;
  op_t                  op_sel;
  logic                 u_done, u_busy;

  always_comb begin
    unique case (cmd.sel)
      SEL_SCALE: begin
        op_a = v_reg; op_b = phat_inv[cmd.pidx]; op_m = p_mod[cmd.pidx]; op_sel = OP_MUL;
      end
      SEL_TERM: begin
        op_a = t_reg; op_b = phat_q[{cmd.pidx, cmd.limb}]; op_m = q_mod[cmd.limb];
        op_sel = OP_MUL;
      end
      SEL_ACC: begin
        op_a = acc[cmd.limb]; op_b = u_res; op_m = q_mod[cmd.limb]; op_sel = OP_ADD;
      end
      SEL_DIFF: begin
        op_a = q_res[cmd.limb]; op_b = acc[cmd.limb]; op_m = q_mod[cmd.limb]; op_sel = OP_SUB;
      end
      SEL_OUT: begin
        op_a = u_res; op_b = p_inv[cmd.limb]; op_m = q_mod[cmd.limb]; op_sel = OP_MUL;
      end
      default: begin
        op_a = '0; op_b = '0; op_m = '0; op_sel = OP_MUL;
      end
    endcase
  end

  rmd_modarith u_arith (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.start),
    .op     (op_sel),
    .a      (op_a),
    .b      (op_b),
    .m      (op_m),
    .done   (u_done),
    .busy   (u_busy),
    .result (u_res)
  );

  assign status.done     = u_done;
  assign status.busy     = u_busy;
  assign status.out_free = !out_valid || !out_stall;

  // Table and residue writes happen on the accepting edge.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      v_reg <= value;
      if (command == CMD_LOAD) begin
        unique case (table_req)
          TBL_Q_MOD:    q_mod[q_index]               <= value;
          TBL_P_MOD:    p_mod[p_index]               <= value;
          TBL_PHAT_INV: phat_inv[p_index]            <= value;
          TBL_PHAT_Q:   phat_q[{p_index, q_index}]   <= value;
          TBL_P_INV:    p_inv[q_index]               <= value;
          default: ;
        endcase
      end else if (!in_p_basis) begin
        q_res[q_index] <= value;
      end
    end
    if (u_done && cmd.sel == SEL_SCALE) begin
      t_reg <= u_res;
    end
    if (cmd.load_out) begin
      limb    <= cmd.limb;
      residue <= u_res;
      last    <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_Q_LIMBS; i++) begin
        acc[i] <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      if (u_done && cmd.sel == SEL_ACC) begin
        acc[cmd.limb] <= u_res;
      end
      if (cmd.load_out) begin
        acc[cmd.limb] <= '0;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/rmd_ctrl.sv =====
module rmd_ctrl
  import rmd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [QCNT_W-1:0]  cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic               in_p_basis,
  input  logic [P_IDX_W-1:0] p_index,
  output ctl_cmd_t           cmd,
  input  dp_stat_t           status
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCALE = 7'b0000010,
    S_TERM  = 7'b0000100,
    S_ACC   = 7'b0001000,
    S_DIFF  = 7'b0010000,
    S_OUTM  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t             state, state_next;
  logic [QCNT_W-1:0]  q_limbs;
  logic [PCNT_W-1:0]  p_limbs;
  logic [QCNT_W-1:0]  nq;
  logic [PCNT_W-1:0]  np;
  logic [Q_IDX_W-1:0] i_cnt, i_cnt_next;
  logic [P_IDX_W-1:0] p_cur;
  logic               launch, launch_next, accept, last_limb, closing;

  always_comb begin
    if (q_limbs == '0) nq = QCNT_W'(1);
    else if (q_limbs > QCNT_W'(MAX_Q_LIMBS)) nq = QCNT_W'(MAX_Q_LIMBS);
    else nq = q_limbs;
    if (p_limbs == '0) np = PCNT_W'(1);
    else if (p_limbs > PCNT_W'(MAX_P_LIMBS)) np = PCNT_W'(MAX_P_LIMBS);
    else np = p_limbs;
  end

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign last_limb = ({1'b0, i_cnt} == nq - 1'b1);
  assign closing   = ({1'b0, p_cur} == np - 1'b1);

  always_comb begin
    state_next  = state;
    i_cnt_next  = i_cnt;
    launch_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept && command == CMD_RES && in_p_basis && {1'b0, p_index} < np) begin
          state_next  = S_SCALE;
          launch_next = 1'b1;
        end
      end
      S_SCALE: begin
        if (status.done) begin
          state_next = S_TERM; i_cnt_next = '0; launch_next = 1'b1;
        end
      end
      S_TERM: begin
        if (status.done) begin
          state_next = S_ACC; launch_next = 1'b1;
        end
      end
      S_ACC: begin
        if (status.done) begin
          if (!last_limb) begin
            state_next = S_TERM; i_cnt_next = i_cnt + 1'b1; launch_next = 1'b1;
          end else if (closing) begin
            state_next = S_DIFF; i_cnt_next = '0; launch_next = 1'b1;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_DIFF: begin
        if (status.done) begin
          state_next = S_OUTM; launch_next = 1'b1;
        end
      end
      S_OUTM: begin
        if (status.done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          if (last_limb) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_DIFF; i_cnt_next = i_cnt + 1'b1; launch_next = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.start    = launch;
    cmd.limb     = i_cnt;
    cmd.pidx     = p_cur;
    cmd.accept   = accept;
    cmd.load_out = (state == S_EMIT) && status.out_free;
    cmd.last     = last_limb;
    unique case (state)
      S_SCALE: cmd.sel = SEL_SCALE;
      S_TERM:  cmd.sel = SEL_TERM;
      S_ACC:   cmd.sel = SEL_ACC;
      S_DIFF:  cmd.sel = SEL_DIFF;
      S_OUTM:  cmd.sel = SEL_OUT;
      default: cmd.sel = SEL_OUT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      launch  <= 1'b0;
      i_cnt   <= '0;
      p_cur   <= '0;
      q_limbs <= QCNT_W'(1);
      p_limbs <= PCNT_W'(1);
    end else begin
      state  <= state_next;
      launch <= launch_next;
      i_cnt  <= i_cnt_next;
      if (accept) p_cur <= p_index;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_Q_LIMBS: q_limbs <= cfg_data;
          REG_P_LIMBS: p_limbs <= cfg_data[PCNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== design/rns_mod_down_top.sv =====
// Channel | Direction | Handshake            | Word
// in      | input     | in_valid / in_stall  | command, table_req, p_index, q_index, in_p_basis, value
// out     | output    | out_valid / out_stall| limb, residue, last
// cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// A table load or a Q residue is written on accept. A P residue runs its scaling multiply
// and, per Q limb in use, a multiply and an add on one shared bit-serial modular unit.
// Closing a coefficient (the P residue of the last P limb in use) then runs a subtract and
// a multiply per Q limb in use and emits each limb once the output is free.
// Reset is synchronous and clears the controller, the accumulators and the output valid.
// A stalled output word holds while the next limb is computed; input stalls while busy.
module rns_mod_down_top
  import rmd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [QCNT_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 command,
  input  logic [2:0]           table_req,
  input  logic [P_IDX_W-1:0]   p_index,
  input  logic [Q_IDX_W-1:0]   q_index,
  input  logic                 in_p_basis,
  input  logic [WORD_BITS-1:0] value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [Q_IDX_W-1:0]   limb,
  output logic [WORD_BITS-1:0] residue,
  output logic                 last
);

  // The controller sequences the arithmetic; the datapath owns all tables,
  // accumulators, the shared modular unit and the output register.
  ctl_cmd_t cmd;
  dp_stat_t status;

  rmd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .in_p_basis (in_p_basis),
    .p_index    (p_index),
    .cmd        (cmd),
    .status     (status)
  );

  rmd_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .command    (command),
    .table_req  (table_req),
    .p_index    (p_index),
    .q_index    (q_index),
    .in_p_basis (in_p_basis),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .limb       (limb),
    .residue    (residue),
    .last       (last)
  );

`ifndef ASSERT_OFF
  // An input word is only taken while the modular unit is quiet.
  a_idle_accept: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !status.busy) else $error("input accepted while unit busy");

  // Every launch puts the modular unit to work on the next cycle.
  a_launch_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> status.busy) else $error("launch did not start the unit");

  // A result is written to the output register only from a finished operation.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !status.busy) else $error("output loaded while unit busy");
`endif

endmodule
